>>> hw/rtl/session_progress_color_resolver_top_assert.svh
// Assertion macros for the session progress color resolver; empty when synthesizing.
`ifndef SESSION_PROGRESS_COLOR_RESOLVER_TOP_ASSERT_SVH
`define SESSION_PROGRESS_COLOR_RESOLVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every clock edge outside of reset.
`define SPCR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spcr assertion failed");

// Check a property at every clock edge, reset included.
`define SPCR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("spcr assertion failed");

`else

`define SPCR_ASSERT(lbl, clk, rst_n, prop)
`define SPCR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hw/rtl/spcr_pkg.sv
// Shared types and constants of the session progress color resolver.
package spcr_pkg;

  localparam int unsigned ModeW     = 3;
  localparam int unsigned ProgressW = 8;
  localparam int unsigned ElapsedW  = 32;
  localparam int unsigned ChanW     = 8;

  // Light mode codes
  localparam logic [ModeW-1:0] MODE_OFF       = 3'd0;
  localparam logic [ModeW-1:0] MODE_ACTIVE    = 3'd1;
  localparam logic [ModeW-1:0] MODE_PAUSED    = 3'd2;
  localparam logic [ModeW-1:0] MODE_OVERTIME  = 3'd3;
  localparam logic [ModeW-1:0] MODE_EMERGENCY = 3'd4;

  // Gradient breakpoints in percent
  localparam logic [ProgressW-1:0] PROGRESS_MAX = 8'd100;
  localparam logic [6:0]           SEG_YO_START = 7'd50;
  localparam logic [6:0]           SEG_OR_START = 7'd75;

  // Rounding offsets: half of 50 and half of 25
  localparam logic [14:0] HALF_50 = 15'd25;
  localparam logic [12:0] HALF_25 = 13'd12;

  // Divide by 25 as multiply by ceil(2^17 / 25) and shift, exact below 43690
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned NumW        = 13;
  localparam int unsigned ProdW       = 26;

  // Channel levels of the gradient colors
  localparam logic [ChanW-1:0] CHAN_FULL     = 8'd255;
  localparam logic [ChanW-1:0] CHAN_ORANGE_G = 8'd128;
  localparam logic [ChanW-1:0] CHAN_ZERO     = 8'd0;

  // Blink: residues of powers of two modulo the 1000 ms period
  localparam logic [9:0]  RES_2P16    = 10'd536;
  localparam logic [7:0]  RES_2P13    = 8'd192;
  localparam logic [4:0]  RES_2P10    = 5'd24;
  localparam logic [10:0] BLINK_PERIOD = 11'd1000;
  localparam logic [10:0] BLINK_ON     = 11'd500;

  typedef enum logic [1:0] {
    SRC_BLACK,
    SRC_GRAD,
    SRC_BLINK
  } color_src_e;

  typedef enum logic [1:0] {
    SEG_GY,
    SEG_YO,
    SEG_OR
  } grad_seg_e;

  // Load enables of the two datapath stages ahead of the output register
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

>>> hw/rtl/spcr_if.sv
// Valid/ready channel interfaces for input items and result colors.
interface spcr_item_if;
  import spcr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ModeW-1:0]     mode;
  logic [ProgressW-1:0] progress;
  logic [ElapsedW-1:0]  elapsed_ms;

  modport source (output valid, output mode, output progress, output elapsed_ms,
                  input ready);
  modport sink   (input valid, input mode, input progress, input elapsed_ms,
                  output ready);
endinterface

interface spcr_color_if;
  import spcr_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

>>> hw/rtl/spcr_grad.sv
// Progress gradient datapath: segment pick, numerator, divide by 25, blend.
module spcr_grad (
  input  logic                          clk_i,
  input  spcr_pkg::stage_en_t           en_i,
  input  logic [spcr_pkg::ProgressW-1:0] progress_i,
  output logic [spcr_pkg::ChanW-1:0]    red_o,
  output logic [spcr_pkg::ChanW-1:0]    green_o
);
  import spcr_pkg::*;

  logic [6:0]      pct;
  logic [6:0]      ofs;
  logic [14:0]     p255;
  grad_seg_e       seg_d;
  logic [NumW-1:0] num_d;
  grad_seg_e       seg1_q, seg2_q;
  logic [NumW-1:0] num1_q;
  logic [ProdW-1:0] prod2_q;
  logic [ChanW-1:0] quo;

  // Clamp progress and form the rounded numerator of the segment
  always_comb begin
    pct  = (progress_i > PROGRESS_MAX) ? PROGRESS_MAX[6:0] : progress_i[6:0];
    p255 = {pct, 8'b0} - {8'b0, pct};
    ofs  = '0;
    if (pct <= SEG_YO_START) begin
      seg_d = SEG_GY;
      num_d = NumW'((p255 + HALF_50) >> 1);
    end else if (pct <= SEG_OR_START) begin
      seg_d = SEG_YO;
      ofs   = pct - SEG_YO_START;
      num_d = {1'b0, ofs[4:0], 7'b0} - {8'b0, ofs[4:0]} + HALF_25;
    end else begin
      seg_d = SEG_OR;
      ofs   = pct - SEG_OR_START;
      num_d = {1'b0, ofs[4:0], 7'b0} + HALF_25;
    end
  end

  // Stage 1: hold segment and numerator
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      seg1_q <= seg_d;
      num1_q <= num_d;
    end
  end

  // Stage 2: multiply by the reciprocal of 25
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      seg2_q  <= seg1_q;
      prod2_q <= ProdW'(num1_q * RECIP_25);
    end
  end

  // Take the quotient and blend from the segment start color
  always_comb begin
    quo = prod2_q[RECIP_SHIFT +: ChanW];
    case (seg2_q)
      SEG_GY: begin
        red_o   = quo;
        green_o = CHAN_FULL;
      end
      SEG_YO: begin
        red_o   = CHAN_FULL;
        green_o = CHAN_FULL - quo;
      end
      SEG_OR: begin
        red_o   = CHAN_FULL;
        green_o = CHAN_ORANGE_G - quo;
      end
      default: begin
        red_o   = CHAN_ZERO;
        green_o = CHAN_ZERO;
      end
    endcase
  end

endmodule

>>> hw/rtl/spcr_blink.sv
// Blink phase datapath: elapsed time folded modulo 1000 ms over the pipeline.
module spcr_blink (
  input  logic                         clk_i,
  input  spcr_pkg::stage_en_t          en_i,
  input  logic [spcr_pkg::ElapsedW-1:0] elapsed_ms_i,
  output logic                         on_o
);
  import spcr_pkg::*;

  logic [25:0] fold1_q;
  logic [19:0] fold2_q;
  logic [14:0] fold3;
  logic [10:0] fold4;
  logic [10:0] phase;

  // Stage 1: fold the upper half using 2^16 mod 1000
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      fold1_q <= 26'(elapsed_ms_i[31:16] * RES_2P16) + 26'(elapsed_ms_i[15:0]);
    end
  end

  // Stage 2: fold above bit 13 using 2^13 mod 1000
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      fold2_q <= 20'(fold1_q[25:13] * RES_2P13) + 20'(fold1_q[12:0]);
    end
  end

  // Fold twice above bit 10, then one conditional subtract gives the phase
  always_comb begin
    fold3 = 15'(fold2_q[19:10] * RES_2P10) + 15'(fold2_q[9:0]);
    fold4 = 11'(fold3[14:10] * RES_2P10) + 11'(fold3[9:0]);
    phase = (fold4 >= BLINK_PERIOD) ? fold4 - BLINK_PERIOD : fold4;
    on_o  = (phase < BLINK_ON);
  end

endmodule

>>> hw/rtl/session_progress_color_resolver_top.sv
// Top level of the session progress color resolver: stage control and output register.
//
//   channel  dir  beat
//   item_i   in   mode[2:0], progress[7:0], elapsed_ms[31:0]
//   color_o  out  red[7:0], green[7:0], blue[7:0]
//
// One color per item, one item per cycle when the output is taken.
// Items pass through two datapath stages and the output register; the stages
// carry the divide-by-25 multiply and the modulo-1000 folding chain.
// Reset empties every stage; payload registers are not reset.
// Each stage loads when it is empty or its successor moves, so bubbles
// close up behind a stalled output and no beat is lost or repeated.
`include "session_progress_color_resolver_top_assert.svh"

module session_progress_color_resolver_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  spcr_item_if.sink    item_i,
  spcr_color_if.source color_o
);
  import spcr_pkg::*;

  logic             v1_q, v2_q, v3_q;
  logic             rdy1, rdy2, rdy3;
  stage_en_t        en;
  color_src_e       src_d, src1_q, src2_q;
  logic [ChanW-1:0] grad_r, grad_g;
  logic             blink_on;
  logic [ChanW-1:0] red_d, green_d;
  logic [ChanW-1:0] red_q, green_q;

  // Advance a stage when it is empty or the next one takes its beat
  assign rdy3   = !v3_q || color_o.ready;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign en.s1  = rdy1;
  assign en.s2  = rdy2;
  assign item_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= item_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Decode the mode into a color source
  always_comb begin
    case (item_i.mode)
      MODE_ACTIVE, MODE_PAUSED:      src_d = SRC_GRAD;
      MODE_OVERTIME, MODE_EMERGENCY: src_d = SRC_BLINK;
      default:                       src_d = SRC_BLACK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) src1_q <= src_d;
    if (en.s2) src2_q <= src1_q;
  end

  spcr_grad u_grad (
    .clk_i      (clk_i),
    .en_i       (en),
    .progress_i (item_i.progress),
    .red_o      (grad_r),
    .green_o    (grad_g)
  );

  spcr_blink u_blink (
    .clk_i        (clk_i),
    .en_i         (en),
    .elapsed_ms_i (item_i.elapsed_ms),
    .on_o         (blink_on)
  );

  // Pick the final color from the source
  always_comb begin
    case (src2_q)
      SRC_GRAD: begin
        red_d   = grad_r;
        green_d = grad_g;
      end
      SRC_BLINK: begin
        red_d   = blink_on ? CHAN_FULL : CHAN_ZERO;
        green_d = CHAN_ZERO;
      end
      default: begin
        red_d   = CHAN_ZERO;
        green_d = CHAN_ZERO;
      end
    endcase
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      red_q   <= red_d;
      green_q <= green_d;
    end
  end

  assign color_o.valid = v3_q;
  assign color_o.red   = red_q;
  assign color_o.green = green_q;
  assign color_o.blue  = CHAN_ZERO;

  `SPCR_ASSERT(a_black_out, clk_i, rst_ni, (v2_q && rdy3 && src2_q == SRC_BLACK) |=> (color_o.red == CHAN_ZERO && color_o.green == CHAN_ZERO))
  `SPCR_ASSERT(a_grad_full, clk_i, rst_ni, (v2_q && rdy3 && src2_q == SRC_GRAD) |=> (color_o.red == CHAN_FULL || color_o.green == CHAN_FULL))
  `SPCR_ASSERT(a_blink_red, clk_i, rst_ni, (v2_q && rdy3 && src2_q == SRC_BLINK) |=> (color_o.green == CHAN_ZERO && (color_o.red == CHAN_ZERO || color_o.red == CHAN_FULL)))
  `SPCR_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> (!v1_q && !v2_q && !v3_q))

endmodule

>>> test/session_progress_color_resolver_top_tb.sv
// Testbench for the session progress color resolver: preset rows, random items, color scoreboard.
`timescale 1ns / 100ps

module session_progress_color_resolver_top_tb;
  import spcr_pkg::*;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [ModeW-1:0]     mode;
    logic [ProgressW-1:0] progress;
    logic [ElapsedW-1:0]  elapsed_ms;
    logic                 fixed;
    rgb_t                 color;
  } preset_row_t;

  // Mode codes with no meaning of their own; they show black
  localparam logic [ModeW-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [ModeW-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_RSVD7 = 3'd7;

  localparam rgb_t CLR_BLACK  = '{8'd0, 8'd0, 8'd0};
  localparam rgb_t CLR_GREEN  = '{8'd0, 8'd255, 8'd0};
  localparam rgb_t CLR_YELLOW = '{8'd255, 8'd255, 8'd0};
  localparam rgb_t CLR_ORANGE = '{8'd255, 8'd128, 8'd0};
  localparam rgb_t CLR_RED    = '{8'd255, 8'd0, 8'd0};

  localparam int unsigned PCT_CAP    = 100;
  localparam int unsigned PERIOD_MS  = 1000;
  localparam int unsigned LIT_MS     = 500;
  localparam int unsigned N_PRESET   = 24;
  localparam int unsigned N_RANDOM   = 1100;
  localparam int unsigned CHOKE_CYC  = 64;
  localparam int unsigned DRAIN_CYC  = 8;

  // Corner rows; fixed = 1 marks a color that is known by inspection
  localparam preset_row_t preset_rows [N_PRESET] = '{
    '{MODE_OFF,       8'd0,   32'd0,          1'b1, CLR_BLACK},
    '{MODE_OFF,       8'd255, 32'hFFFF_FFFF,  1'b1, CLR_BLACK},
    '{MODE_ACTIVE,    8'd0,   32'd0,          1'b1, CLR_GREEN},
    '{MODE_ACTIVE,    8'd50,  32'd123,        1'b1, CLR_YELLOW},
    '{MODE_PAUSED,    8'd75,  32'hFFFF_FFFF,  1'b1, CLR_ORANGE},
    '{MODE_ACTIVE,    8'd100, 32'd0,          1'b1, CLR_RED},
    '{MODE_PAUSED,    8'd101, 32'd700,        1'b1, CLR_RED},
    '{MODE_ACTIVE,    8'd255, 32'd0,          1'b1, CLR_RED},
    '{MODE_ACTIVE,    8'd1,   32'd0,          1'b0, CLR_BLACK},
    '{MODE_PAUSED,    8'd25,  32'd0,          1'b0, CLR_BLACK},
    '{MODE_ACTIVE,    8'd51,  32'd0,          1'b0, CLR_BLACK},
    '{MODE_PAUSED,    8'd62,  32'd0,          1'b0, CLR_BLACK},
    '{MODE_ACTIVE,    8'd76,  32'd0,          1'b0, CLR_BLACK},
    '{MODE_PAUSED,    8'd99,  32'd0,          1'b0, CLR_BLACK},
    '{MODE_OVERTIME,  8'd0,   32'd0,          1'b1, CLR_RED},
    '{MODE_OVERTIME,  8'd50,  32'd499,        1'b1, CLR_RED},
    '{MODE_OVERTIME,  8'd100, 32'd500,        1'b1, CLR_BLACK},
    '{MODE_EMERGENCY, 8'd0,   32'd999,        1'b1, CLR_BLACK},
    '{MODE_EMERGENCY, 8'd255, 32'd1000,       1'b1, CLR_RED},
    '{MODE_OVERTIME,  8'd0,   32'hFFFF_FFFF,  1'b1, CLR_RED},
    '{MODE_EMERGENCY, 8'd0,   32'd4294966999, 1'b1, CLR_BLACK},
    '{MODE_RSVD5,     8'd50,  32'd0,          1'b1, CLR_BLACK},
    '{MODE_RSVD6,     8'd0,   32'd100,        1'b1, CLR_BLACK},
    '{MODE_RSVD7,     8'd100, 32'hFFFF_FFFF,  1'b1, CLR_BLACK}
  };

  logic clk_i;
  logic rst_ni;

  spcr_item_if  item_bus ();
  spcr_color_if color_bus ();

  session_progress_color_resolver_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .color_o (color_bus)
  );

  // Sideband that travels with each beat: a hand-written color, if any
  logic  row_fixed;
  rgb_t  row_color;

  rgb_t        colors_due [$];
  int unsigned errors;
  int unsigned colors_checked;
  int unsigned n_grad, n_blink, n_black;
  int unsigned stall_cycles;
  int unsigned choke_requests;
  bit          sender_steady;

  // One channel of a linear blend, rounded half away from zero
  function automatic logic [ChanW-1:0] mix_channel(int from, int to, int num, int den);
    int prod;
    int half;
    prod = (to - from) * num;
    half = den / 2;
    if (prod < 0) begin
      half = -half;
    end
    return 8'(from + (prod + half) / den);
  endfunction

  function automatic rgb_t mix_rgb(rgb_t a, rgb_t b, int num, int den);
    rgb_t c;
    c.red   = mix_channel(a.red, b.red, num, den);
    c.green = mix_channel(a.green, b.green, num, den);
    c.blue  = mix_channel(a.blue, b.blue, num, den);
    return c;
  endfunction

  // Color that the resolver must show for one item
  function automatic rgb_t resolve_color(logic [ModeW-1:0] mode, logic [ProgressW-1:0] pct,
                                         logic [ElapsedW-1:0] elapsed);
    int p;
    case (mode)
      MODE_ACTIVE, MODE_PAUSED: begin
        p = (int'(pct) > PCT_CAP) ? PCT_CAP : int'(pct);
        if (p <= 50) begin
          return mix_rgb(CLR_GREEN, CLR_YELLOW, p, 50);
        end else if (p <= 75) begin
          return mix_rgb(CLR_YELLOW, CLR_ORANGE, p - 50, 25);
        end
        return mix_rgb(CLR_ORANGE, CLR_RED, p - 75, 25);
      end
      MODE_OVERTIME, MODE_EMERGENCY: begin
        return ((elapsed % 32'(PERIOD_MS)) < 32'(LIT_MS)) ? CLR_RED : CLR_BLACK;
      end
      default: begin
        return CLR_BLACK;
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [ChanW-1:0] want, logic [ChanW-1:0] got);
    if (got !== want) begin
      $error("color field %s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Offer one beat, after a random gap unless the sender runs steady, and hold it until the block takes it
  task automatic offer_item(logic [ModeW-1:0] mode, logic [ProgressW-1:0] pct,
                            logic [ElapsedW-1:0] elapsed, logic fixed, rgb_t color);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid      <= 1'b1;
    item_bus.mode       <= mode;
    item_bus.progress   <= pct;
    item_bus.elapsed_ms <= elapsed;
    row_fixed           <= fixed;
    row_color           <= color;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
  endtask

  // Draw one random item, partly near the gradient and blink edges
  task automatic draw_item(output logic [ModeW-1:0] mode, output logic [ProgressW-1:0] pct,
                           output logic [ElapsedW-1:0] elapsed);
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick <= 6) begin
      mode = $urandom_range(0, 1) ? MODE_ACTIVE : MODE_PAUSED;
    end else if (pick <= 11) begin
      mode = $urandom_range(0, 1) ? MODE_OVERTIME : MODE_EMERGENCY;
    end else if (pick <= 13) begin
      mode = MODE_OFF;
    end else begin
      mode = 3'($urandom_range(MODE_RSVD5, MODE_RSVD7));
    end

    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      pct = 8'($urandom_range(0, PCT_CAP));
    end else if (pick == 6) begin
      pct = 8'($urandom_range(0, 2) + ($urandom_range(0, 1) ? 49 : 74));
    end else if (pick <= 8) begin
      pct = 8'($urandom_range(0, 255));
    end else begin
      pct = 8'($urandom_range(PCT_CAP + 1, 255));
    end

    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      elapsed = $urandom();
    end else if (pick <= 6) begin
      elapsed = 32'($urandom_range(0, 4294966)) * 32'(PERIOD_MS);
      elapsed = elapsed + ($urandom_range(0, 1) ? $urandom_range(LIT_MS - 5, LIT_MS + 4)
                                                 : $urandom_range(PERIOD_MS - 5, PERIOD_MS + 4));
    end else begin
      elapsed = $urandom_range(0, 3 * PERIOD_MS - 1);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Scoreboard: predict on each accepted item, compare each accepted color
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni) begin
      if (item_bus.valid && item_bus.ready) begin
        colors_due.push_back(row_fixed ? row_color
                             : resolve_color(item_bus.mode, item_bus.progress, item_bus.elapsed_ms));
        case (item_bus.mode)
          MODE_ACTIVE, MODE_PAUSED:      n_grad++;
          MODE_OVERTIME, MODE_EMERGENCY: n_blink++;
          default:                       n_black++;
        endcase
      end
      if (item_bus.valid && !item_bus.ready) begin
        stall_cycles++;
      end
      if (color_bus.valid && color_bus.ready) begin
        if (colors_due.size() == 0) begin
          $error("color beat with no item waiting: r=%0d g=%0d b=%0d",
                 color_bus.red, color_bus.green, color_bus.blue);
          errors++;
        end else begin
          want = colors_due.pop_front();
          check_field("red", want.red, color_bus.red);
          check_field("green", want.green, color_bus.green);
          check_field("blue", want.blue, color_bus.blue);
          colors_checked++;
        end
      end
    end
  end

  // Color sink: random stalls, steady stretches, long hold-offs on request
  initial begin : color_sink
    int unsigned hold;
    int unsigned beats;
    int unsigned chokes_done;
    beats       = 0;
    chokes_done = 0;
    color_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (choke_requests > chokes_done) begin
        chokes_done++;
        hold = CHOKE_CYC;
      end else if ((beats / 150) % 3 == 2) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 7);
      end
      if (hold != 0) begin
        color_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      color_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!color_bus.valid) @(posedge clk_i);
      beats++;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [ModeW-1:0]     mode;
    logic [ProgressW-1:0] pct;
    logic [ElapsedW-1:0]  elapsed;
    errors         = 0;
    colors_checked = 0;
    n_grad         = 0;
    n_blink        = 0;
    n_black        = 0;
    stall_cycles   = 0;
    choke_requests = 0;
    sender_steady  = 1'b0;
    rst_ni              <= 1'b0;
    item_bus.valid      <= 1'b0;
    item_bus.mode       <= MODE_OFF;
    item_bus.progress   <= '0;
    item_bus.elapsed_ms <= '0;
    row_fixed           <= 1'b0;
    row_color           <= CLR_BLACK;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the corner rows
    for (int unsigned i = 0; i < N_PRESET; i++) begin
      offer_item(preset_rows[i].mode, preset_rows[i].progress, preset_rows[i].elapsed_ms,
                 preset_rows[i].fixed, preset_rows[i].color);
    end

    // Random items; every fourth stretch runs without sender gaps
    for (int unsigned idx = 0; idx < N_RANDOM; idx++) begin
      sender_steady = ((idx / 120) % 4 == 3);
      if (idx == 370 || idx == 850) begin
        choke_requests++;
      end
      draw_item(mode, pct, elapsed);
      offer_item(mode, pct, elapsed, 1'b0, CLR_BLACK);
    end
    item_bus.valid <= 1'b0;

    // Wait for a color per item, then give the pipeline time to show any stray beat
    while (colors_checked < N_PRESET + N_RANDOM) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (colors_due.size() != 0) begin
      $error("colors still owed at end of run: %0d", colors_due.size());
      errors++;
    end

    $display("run: %0d items (%0d corner rows), %0d colors compared", N_PRESET + N_RANDOM,
             N_PRESET, colors_checked);
    $display("run: %0d gradient, %0d blink, %0d black items; %0d input stall cycles",
             n_grad, n_blink, n_black, stall_cycles);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/spcr_pkg.sv
hw/rtl/spcr_if.sv
hw/rtl/spcr_grad.sv
hw/rtl/spcr_blink.sv
hw/rtl/session_progress_color_resolver_top.sv
test/session_progress_color_resolver_top_tb.sv
